// File: hw/rtl/ppd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_pkg
// Types and constants of the palette pixel decoder.
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ColorW = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned MaxCpp = 4;
  localparam int unsigned MaxRow = 2048;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CHAR  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [CfgIdxW-1:0] REG_CPP = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_ROW = 1'b1;

  typedef struct packed {
    logic [1:0]        op;
    logic [KeyW-1:0]   entry_key;
    logic [ColorW-1:0] entry_color;
    logic [ByteW-1:0]  char_byte;
  } in_req_t;

  typedef struct packed {
    logic [ColorW-1:0] pixel_argb;
    logic              found;
    logic              row_end;
  } out_req_t;

  // Token travelling down the cell chain.
  typedef struct packed {
    logic              busy;
    logic              hit;
    logic [KeyW-1:0]   key;
    logic [ColorW-1:0] color;
  } probe_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_OUT    = 2'd2
  } state_e;

endpackage : ppd_pkg
`default_nettype wire

// File: hw/rtl/ppd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppd_cell
// One table slot: holds a key and color, compares a passing probe.
// ----------------------------------------------------------------------------
module ppd_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_i,
  input  wire logic [31:0]     wr_key_i,
  input  wire logic [31:0]     wr_color_i,
  input  wire logic            valid_i,
  input  wire ppd_pkg::probe_t probe_i,
  output ppd_pkg::probe_t      probe_o
);
  import ppd_pkg::*;

  logic [KeyW-1:0]   key_q;
  logic [ColorW-1:0] color_q;
  probe_t            probe_d, probe_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      key_q   <= wr_key_i;
      color_q <= wr_color_i;
    end
  end

  always_comb begin
    probe_d = probe_i;
    if (probe_i.busy && !probe_i.hit && valid_i && (key_q == probe_i.key)) begin
      probe_d.hit   = 1'b1;
      probe_d.color = color_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule : ppd_cell
`default_nettype wire

// File: hw/rtl/palette_pixel_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_pixel_decoder
// Palette lookup of pixel text through a chain of key cells.
// ----------------------------------------------------------------------------
// Loads, clears and pixel characters that do not complete a key give no
// result. A character that completes a key sends it down the chain of
// TABLE_DEPTH cells one cell per cycle; the last cell's probe is then
// registered into the result register, and the result is held until the
// output is not stalled. The next request is taken once the result has been
// delivered.
module palette_pixel_decoder #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ppd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ppd_pkg::CfgW-1:0]      cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire ppd_pkg::in_req_t              in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output ppd_pkg::out_req_t                  out_req_o
);
  import ppd_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  logic [2:0]        cpp_q;
  logic [11:0]       row_q;
  logic [CntW-1:0]   count_q;
  logic [KeyW-1:0]   acc_q;
  logic [1:0]        chars_q;
  logic [10:0]       col_q;
  state_e            state_q, state_d;
  out_req_t          res_q;
  logic              last_q;

  probe_t chain [TABLE_DEPTH+1];

  logic accept, is_load, is_char, is_clear, key_done;
  logic [2:0]  cpp_eff;
  logic [11:0] row_eff;
  logic [KeyW-1:0] key_next;
  logic [11:0] col_inc;

  assign accept   = in_valid_i && !in_stall_o;
  assign is_load  = accept && (in_req_i.op == OP_LOAD);
  assign is_char  = accept && (in_req_i.op == OP_CHAR);
  assign is_clear = accept && (in_req_i.op == OP_CLEAR);

  always_comb begin
    if (cpp_q == 3'd0) cpp_eff = 3'd1;
    else if (cpp_q > 3'(MaxCpp)) cpp_eff = 3'(MaxCpp);
    else cpp_eff = cpp_q;
    if (row_q == 12'd0) row_eff = 12'd1;
    else if (row_q > 12'(MaxRow)) row_eff = 12'(MaxRow);
    else row_eff = row_q;
  end

  assign key_next = {acc_q[KeyW-ByteW-1:0], in_req_i.char_byte};
  assign key_done = ({1'b0, chars_q} + 3'd1) >= cpp_eff;
  assign col_inc  = {1'b0, col_q} + 12'd1;

  assign chain[0].busy  = is_char && key_done;
  assign chain[0].hit   = 1'b0;
  assign chain[0].key   = key_next;
  assign chain[0].color = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ppd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_i       (is_load && (count_q == CntW'(g))),
      .wr_key_i   (in_req_i.entry_key),
      .wr_color_i (in_req_i.entry_color),
      .valid_i    (count_q > CntW'(g)),
      .probe_i    (chain[g]),
      .probe_o    (chain[g+1])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (is_char && key_done) state_d = ST_SEARCH;
      ST_SEARCH: if (chain[TABLE_DEPTH].busy) state_d = ST_OUT;
      ST_OUT:    if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
  end

  assign out_req_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cpp_q   <= 3'd1;
      row_q   <= 12'd1;
      count_q <= '0;
      acc_q   <= '0;
      chars_q <= '0;
      col_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_CPP) cpp_q <= cfg_data_i[2:0];
        else row_q <= cfg_data_i;
      end
      if (is_load && (count_q < CntW'(TABLE_DEPTH))) count_q <= count_q + 1'b1;
      if (is_clear) begin
        count_q <= '0;
        acc_q   <= '0;
        chars_q <= '0;
        col_q   <= '0;
      end
      if (is_char) begin
        if (key_done) begin
          acc_q   <= '0;
          chars_q <= '0;
          if (col_inc >= row_eff) begin
            col_q  <= '0;
            last_q <= 1'b1;
          end else begin
            col_q  <= col_inc[10:0];
            last_q <= 1'b0;
          end
        end else begin
          acc_q   <= key_next;
          chars_q <= chars_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEARCH && chain[TABLE_DEPTH].busy) begin
      res_q.found      <= chain[TABLE_DEPTH].hit;
      res_q.pixel_argb <= chain[TABLE_DEPTH].hit ? chain[TABLE_DEPTH].color : '0;
      res_q.row_end    <= last_q;
    end
  end

endmodule : palette_pixel_decoder
`default_nettype wire
